>>> rtl/core/complex_interface_adapter_timers_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interface adapter timers unit
// Clocked property shorthands; the including module provides i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTERFACE_ADAPTER_TIMERS_UNIT_MACROS_SVH
`define COMPLEX_INTERFACE_ADAPTER_TIMERS_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CIAT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ciat assertion failed");

// Check that cons holds in the cycle after ante.
`define CIAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ciat assertion failed");

`endif

>>> rtl/core/ciat_pkg.sv
// ----------------------------------------------------------------------------
// ciat_pkg
// Shared types and constants for the interface adapter timers unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ciat_pkg;

    // Transaction kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_FLAG  = 2'd3;

    // Register map
    localparam logic [3:0] ADDR_PRA  = 4'd0;
    localparam logic [3:0] ADDR_PRB  = 4'd1;
    localparam logic [3:0] ADDR_DDRA = 4'd2;
    localparam logic [3:0] ADDR_DDRB = 4'd3;
    localparam logic [3:0] ADDR_TALO = 4'd4;
    localparam logic [3:0] ADDR_TAHI = 4'd5;
    localparam logic [3:0] ADDR_TBLO = 4'd6;
    localparam logic [3:0] ADDR_TBHI = 4'd7;
    localparam logic [3:0] ADDR_SDR  = 4'd12;
    localparam logic [3:0] ADDR_ICR  = 4'd13;
    localparam logic [3:0] ADDR_CRA  = 4'd14;
    localparam logic [3:0] ADDR_CRB  = 4'd15;

    // Control register bits
    localparam int CR_START   = 0;
    localparam int CR_ONESHOT = 3;
    localparam int CR_LOAD    = 4;
    localparam int CR_INMODE  = 5;

    localparam logic [7:0] CR_STORE_MASK = 8'hef;
    localparam logic [1:0] CRB_MODE_CASCADE = 2'b10;

    // Interrupt status bits
    localparam int ICR_TA   = 0;
    localparam int ICR_TB   = 1;
    localparam int ICR_SP   = 3;
    localparam int ICR_FLAG = 4;
    localparam int ICR_IR   = 7;
    localparam int ICR_SET  = 7;

    localparam logic [7:0] ICR_READ_MASK = 8'h9f;

    localparam logic [15:0] TIMER_RESET = 16'hffff;

    typedef struct packed {
        logic        run;
        logic [15:0] count;
        logic [15:0] latch;
        logic [15:0] steps;
    } t_tmr_in;

    typedef struct packed {
        logic [15:0] count;
        logic        under;
    } t_tmr_out;

endpackage

`default_nettype wire

>>> rtl/core/complex_interface_adapter_timers_unit.sv
// A result is registered and appears the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless i_out_ready stalls the result register.
// The critical path is timer A's subtract and underflow feeding timer B's cascade.
// Reset (i_rst_n low at a clock edge): timer counters and latches go to 0xffff,
// control, interrupt status, mask, direction and serial registers clear,
// and the result register empties.
// ----------------------------------------------------------------------------
// complex_interface_adapter_timers_unit
// Two 16-bit down timers with latches, one-shot and cascade modes, and
// interrupt control in the classic 6526 register layout, served one
// transaction per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_interface_adapter_timers_unit_macros.svh"

module complex_interface_adapter_timers_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // transaction channel in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_tick_cycles,
    input  logic [7:0]  i_port_pins,
    // result channel out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq_line
);

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [15:0] r_ta_count, n_ta_count;
    logic [15:0] r_ta_latch, n_ta_latch;
    logic [15:0] r_tb_count, n_tb_count;
    logic [15:0] r_tb_latch, n_tb_latch;
    logic [7:0]  r_ctrl_a,   n_ctrl_a;
    logic [7:0]  r_ctrl_b,   n_ctrl_b;
    logic [7:0]  r_irq_status, n_irq_status;
    logic [4:0]  r_irq_mask, n_irq_mask;
    // Port data registers are not kept: reads of PRA and PRB return the pins,
    // so a stored port byte is never visible.
    logic [7:0]  r_ddra, n_ddra;
    logic [7:0]  r_ddrb, n_ddrb;
    logic [7:0]  r_sdr,  n_sdr;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_out_data, n_out_data;
    logic        r_out_irq;

    logic        accept;
    logic        cascade;
    logic [4:0]  mask_set;

    ciat_pkg::t_tmr_in  tmr_a_in,  tmr_b_in;
    ciat_pkg::t_tmr_out tmr_a_out, tmr_b_out;

    // Take a new transaction whenever the result register is empty or drains
    // in this same cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_irq_line  = r_out_irq;

    // ------------------------------------------------------------------
    // Timers: A runs on the tick when started and counting clock cycles;
    // B either counts the same cycles or, in cascade mode, one step per
    // underflow of A in this very tick.
    // ------------------------------------------------------------------
    assign cascade = (r_ctrl_b[6:5] == ciat_pkg::CRB_MODE_CASCADE);

    always_comb begin
        tmr_a_in.run   = (i_req_type == ciat_pkg::REQ_TICK) && r_ctrl_a[ciat_pkg::CR_START]
                         && !r_ctrl_a[ciat_pkg::CR_INMODE];
        tmr_a_in.count = r_ta_count;
        tmr_a_in.latch = r_ta_latch;
        tmr_a_in.steps = i_tick_cycles;

        tmr_b_in.run   = (i_req_type == ciat_pkg::REQ_TICK) && r_ctrl_b[ciat_pkg::CR_START]
                         && (!cascade || tmr_a_out.under);
        tmr_b_in.count = r_tb_count;
        tmr_b_in.latch = r_tb_latch;
        tmr_b_in.steps = cascade ? 16'd1 : i_tick_cycles;
    end

    ciat_timer u_timer_a (
        .i_tmr (tmr_a_in),
        .o_tmr (tmr_a_out)
    );

    ciat_timer u_timer_b (
        .i_tmr (tmr_b_in),
        .o_tmr (tmr_b_out)
    );

    assign mask_set = r_irq_mask | i_write_data[4:0];

    // ------------------------------------------------------------------
    // Next state and read data for the transaction on the input ports
    // ------------------------------------------------------------------
    always_comb begin
        n_ta_count   = r_ta_count;
        n_ta_latch   = r_ta_latch;
        n_tb_count   = r_tb_count;
        n_tb_latch   = r_tb_latch;
        n_ctrl_a     = r_ctrl_a;
        n_ctrl_b     = r_ctrl_b;
        n_irq_status = r_irq_status;
        n_irq_mask   = r_irq_mask;
        n_ddra       = r_ddra;
        n_ddrb       = r_ddrb;
        n_sdr        = r_sdr;
        n_out_data   = 8'h00;

        case (i_req_type)
            ciat_pkg::REQ_READ: begin
                case (i_reg_address)
                    ciat_pkg::ADDR_PRA,
                    ciat_pkg::ADDR_PRB:  n_out_data = i_port_pins;
                    ciat_pkg::ADDR_DDRA: n_out_data = r_ddra;
                    ciat_pkg::ADDR_DDRB: n_out_data = r_ddrb;
                    ciat_pkg::ADDR_TALO: n_out_data = r_ta_count[7:0];
                    ciat_pkg::ADDR_TAHI: n_out_data = r_ta_count[15:8];
                    ciat_pkg::ADDR_TBLO: n_out_data = r_tb_count[7:0];
                    ciat_pkg::ADDR_TBHI: n_out_data = r_tb_count[15:8];
                    ciat_pkg::ADDR_SDR:  n_out_data = r_sdr;
                    ciat_pkg::ADDR_ICR: begin
                        // Read-to-clear: return the flags, then drop them all.
                        n_out_data   = r_irq_status & ciat_pkg::ICR_READ_MASK;
                        n_irq_status = 8'h00;
                    end
                    ciat_pkg::ADDR_CRA:  n_out_data = r_ctrl_a;
                    ciat_pkg::ADDR_CRB:  n_out_data = r_ctrl_b;
                    default:             n_out_data = 8'h00;
                endcase
            end

            ciat_pkg::REQ_WRITE: begin
                case (i_reg_address)
                    ciat_pkg::ADDR_PRA,
                    ciat_pkg::ADDR_PRB: begin
                        // no visible effect
                    end
                    ciat_pkg::ADDR_DDRA: n_ddra = i_write_data;
                    ciat_pkg::ADDR_DDRB: n_ddrb = i_write_data;
                    ciat_pkg::ADDR_TALO: n_ta_latch[7:0] = i_write_data;
                    ciat_pkg::ADDR_TAHI: begin
                        // A stopped timer also loads its counter from the new latch.
                        n_ta_latch[15:8] = i_write_data;
                        if (!r_ctrl_a[ciat_pkg::CR_START]) begin
                            n_ta_count = {i_write_data, r_ta_latch[7:0]};
                        end
                    end
                    ciat_pkg::ADDR_TBLO: n_tb_latch[7:0] = i_write_data;
                    ciat_pkg::ADDR_TBHI: begin
                        n_tb_latch[15:8] = i_write_data;
                        if (!r_ctrl_b[ciat_pkg::CR_START]) begin
                            n_tb_count = {i_write_data, r_tb_latch[7:0]};
                        end
                    end
                    ciat_pkg::ADDR_SDR: begin
                        n_sdr = i_write_data;
                        n_irq_status[ciat_pkg::ICR_SP] = 1'b1;
                        if (r_irq_mask[ciat_pkg::ICR_SP]) begin
                            n_irq_status[ciat_pkg::ICR_IR] = 1'b1;
                        end
                    end
                    ciat_pkg::ADDR_ICR: begin
                        // Set/clear mask write; a newly enabled pending source raises IR.
                        if (i_write_data[ciat_pkg::ICR_SET]) begin
                            n_irq_mask = mask_set;
                            if ((r_irq_status[4:0] & mask_set) != 5'd0) begin
                                n_irq_status[ciat_pkg::ICR_IR] = 1'b1;
                            end
                        end else begin
                            n_irq_mask = r_irq_mask & ~i_write_data[4:0];
                        end
                    end
                    ciat_pkg::ADDR_CRA: begin
                        // LOAD strobes a counter reload and is never stored.
                        n_ctrl_a = i_write_data & ciat_pkg::CR_STORE_MASK;
                        if (i_write_data[ciat_pkg::CR_LOAD]) begin
                            n_ta_count = r_ta_latch;
                        end
                    end
                    ciat_pkg::ADDR_CRB: begin
                        n_ctrl_b = i_write_data & ciat_pkg::CR_STORE_MASK;
                        if (i_write_data[ciat_pkg::CR_LOAD]) begin
                            n_tb_count = r_tb_latch;
                        end
                    end
                    default: begin
                        // time of day and alarm: ignored
                    end
                endcase
            end

            ciat_pkg::REQ_TICK: begin
                n_ta_count = tmr_a_out.count;
                n_tb_count = tmr_b_out.count;
                if (tmr_a_out.under) begin
                    n_irq_status[ciat_pkg::ICR_TA] = 1'b1;
                    if (r_ctrl_a[ciat_pkg::CR_ONESHOT]) begin
                        n_ctrl_a[ciat_pkg::CR_START] = 1'b0;
                    end
                end
                if (tmr_b_out.under) begin
                    n_irq_status[ciat_pkg::ICR_TB] = 1'b1;
                    if (r_ctrl_b[ciat_pkg::CR_ONESHOT]) begin
                        n_ctrl_b[ciat_pkg::CR_START] = 1'b0;
                    end
                end
                // Any enabled flag among the low four raises IR after a tick.
                if ((n_irq_status[3:0] & r_irq_mask[3:0]) != 4'd0) begin
                    n_irq_status[ciat_pkg::ICR_IR] = 1'b1;
                end
            end

            ciat_pkg::REQ_FLAG: begin
                n_irq_status[ciat_pkg::ICR_FLAG] = 1'b1;
                if (r_irq_mask[ciat_pkg::ICR_FLAG]) begin
                    n_irq_status[ciat_pkg::ICR_IR] = 1'b1;
                end
            end

            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Valid drains on ready; state and r_out_data load only on an accepted transaction
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta_count   <= ciat_pkg::TIMER_RESET;
            r_ta_latch   <= ciat_pkg::TIMER_RESET;
            r_tb_count   <= ciat_pkg::TIMER_RESET;
            r_tb_latch   <= ciat_pkg::TIMER_RESET;
            r_ctrl_a     <= 8'h00;
            r_ctrl_b     <= 8'h00;
            r_irq_status <= 8'h00;
            r_irq_mask   <= 5'd0;
            r_ddra       <= 8'h00;
            r_ddrb       <= 8'h00;
            r_sdr        <= 8'h00;
        end else if (accept) begin
            r_ta_count   <= n_ta_count;
            r_ta_latch   <= n_ta_latch;
            r_tb_count   <= n_tb_count;
            r_tb_latch   <= n_tb_latch;
            r_ctrl_a     <= n_ctrl_a;
            r_ctrl_b     <= n_ctrl_b;
            r_irq_status <= n_irq_status;
            r_irq_mask   <= n_irq_mask;
            r_ddra       <= n_ddra;
            r_ddrb       <= n_ddrb;
            r_sdr        <= n_sdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_irq   <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_out_irq   <= n_irq_status[ciat_pkg::ICR_IR];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CIAT_ASSERT_SAME(a_irq_matches_status, r_out_valid, r_out_irq == r_irq_status[ciat_pkg::ICR_IR])
    `CIAT_ASSERT_NEXT(a_icr_read_clears, accept && (i_req_type == ciat_pkg::REQ_READ) && (i_reg_address == ciat_pkg::ADDR_ICR), r_irq_status == 8'h00)
    `CIAT_ASSERT_NEXT(a_oneshot_stops_a, accept && tmr_a_out.under && r_ctrl_a[ciat_pkg::CR_ONESHOT], !r_ctrl_a[ciat_pkg::CR_START])
    `CIAT_ASSERT_SAME(a_load_not_stored, r_out_valid, !r_ctrl_a[ciat_pkg::CR_LOAD] && !r_ctrl_b[ciat_pkg::CR_LOAD])

endmodule

`default_nettype wire

>>> rtl/core/ciat_timer.sv
// ----------------------------------------------------------------------------
// ciat_timer
// Down counter step: subtract a step count and reload from the latch on underflow.
// ----------------------------------------------------------------------------
`default_nettype none

module ciat_timer (
    input  ciat_pkg::t_tmr_in  i_tmr,
    output ciat_pkg::t_tmr_out o_tmr
);

    logic [16:0] diff;

    // Borrow out of the subtract marks an underflow; the wrapped difference is
    // then the negative remainder to add to the latch.
    assign diff = {1'b0, i_tmr.count} - {1'b0, i_tmr.steps};

    always_comb begin
        o_tmr.count = i_tmr.count;
        o_tmr.under = 1'b0;
        if (i_tmr.run) begin
            o_tmr.under = diff[16];
            if (diff[16]) begin
                o_tmr.count = i_tmr.latch + diff[15:0];
            end else begin
                o_tmr.count = diff[15:0];
            end
        end
    end

endmodule

`default_nettype wire
